### design/lsol_pkg.sv
package lsol_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int BUILTIN_COUNT = 28;
    localparam int BI_W          = $clog2(BUILTIN_COUNT);
    localparam int OFF_W         = 10;
    localparam int TIME_W        = 64;
    localparam int ENT_W         = TIME_W + OFF_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0] NTP_TO_UTC   = 64'd2208988800;
    localparam logic [TIME_W-1:0] EXPIRY_RESET = 64'd1751068800;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_AMBIG   = 2'd2,
        STAT_EXPIRED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } t_bstate;

    // append: arg is the UTC start; query: arg is the time to convert
    typedef struct packed {
        t_op                      op;
        logic [TIME_W-1:0]        arg;
        logic signed [OFF_W-1:0]  off;
    } t_item;

    typedef struct packed {
        logic              busy;
        logic [CNT_W-1:0]  count;
    } t_bk_status;

    function automatic logic [TIME_W-1:0] builtin_start(input logic [BI_W-1:0] i);
        logic [TIME_W-1:0] v;
        case (i)
            5'd0:    v = 64'd63072000;
            5'd1:    v = 64'd78796800;
            5'd2:    v = 64'd94694400;
            5'd3:    v = 64'd126230400;
            5'd4:    v = 64'd157766400;
            5'd5:    v = 64'd189302400;
            5'd6:    v = 64'd220924800;
            5'd7:    v = 64'd252460800;
            5'd8:    v = 64'd283996800;
            5'd9:    v = 64'd315532800;
            5'd10:   v = 64'd362793600;
            5'd11:   v = 64'd394329600;
            5'd12:   v = 64'd425865600;
            5'd13:   v = 64'd489024000;
            5'd14:   v = 64'd567993600;
            5'd15:   v = 64'd631152000;
            5'd16:   v = 64'd662688000;
            5'd17:   v = 64'd709948800;
            5'd18:   v = 64'd741484800;
            5'd19:   v = 64'd773020800;
            5'd20:   v = 64'd820454400;
            5'd21:   v = 64'd867715200;
            5'd22:   v = 64'd915148800;
            5'd23:   v = 64'd1136073600;
            5'd24:   v = 64'd1230768000;
            5'd25:   v = 64'd1341100800;
            5'd26:   v = 64'd1435708800;
            5'd27:   v = 64'd1483228800;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OFF_W-1:0] builtin_offset(input logic [BI_W-1:0] i);
        return {{(OFF_W-BI_W){1'b0}}, i} + OFF_W'(10);
    endfunction

endpackage

### design/lsol_front.sv
module lsol_front import lsol_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_cmd,
    input  logic [TIME_W-1:0]        i_entry_ntp,
    input  logic signed [OFF_W-1:0]  i_entry_offset,
    input  logic [TIME_W-1:0]        i_query_time,
    output logic                     o_push,
    output t_item                    o_item,
    input  logic                     i_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  n_keep;
    logic  accept;

    assign o_push     = r_valid && !i_full;
    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    // classify the beat; the NTP-to-UTC shift happens here
    always_comb begin
        n_item = '{op: OP_QUERY, arg: i_query_time, off: i_entry_offset};
        n_keep = 1'b1;
        unique case (i_cmd)
            CMD_CLEAR: begin
                n_item.op = OP_CLEAR;
            end
            CMD_APPEND: begin
                n_item.op  = OP_APPEND;
                n_item.arg = i_entry_ntp - NTP_TO_UTC;
            end
            CMD_QUERY: begin
                n_item.op = OP_QUERY;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### design/lsol_queue.sv
module lsol_queue import lsol_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_full,
    input  logic   i_pop,
    output t_item  o_item,
    output logic   o_empty
);

    t_item                r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_fill;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_fill == Q_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### design/lsol_back.sv
module lsol_back import lsol_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  t_item                    i_item,
    output logic                     o_pop,
    input  logic [TIME_W-1:0]        i_expiration,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [OFF_W-1:0]  o_leap_offset,
    output t_bk_status               o_stat
);

    t_bstate                  r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [TIME_W-1:0]        r_t, n_t;
    logic                     r_late, n_late;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_iss, n_iss;
    logic                     r_rvld, n_rvld;
    logic [IDX_W-1:0]         r_ridx, n_ridx;
    logic                     r_have_prev, n_have_prev;
    logic [TIME_W-1:0]        r_prev_m1, n_prev_m1;
    t_status                  r_res_st, n_res_st;
    logic signed [OFF_W-1:0]  r_res_off, n_res_off;
    logic [BUILTIN_COUNT-1:0] r_ovr, n_ovr;

    logic [ENT_W-1:0]         mem [TABLE_DEPTH];
    logic [ENT_W-1:0]         r_rd_data;
    logic                     r_rd_bi;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;

    logic                     r_out_valid;
    t_status                  r_out_st;
    logic signed [OFF_W-1:0]  r_out_off;

    logic                     out_free;
    logic                     load_out;
    logic [TIME_W-1:0]        cur_start;
    logic signed [OFF_W-1:0]  cur_off;
    logic                     hit;
    logic [CNT_W-1:0]         cnt_m1;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_out  = (r_state == S_POST) && out_free;
    assign cnt_m1    = r_count - CNT_W'(1);
    assign cur_start = r_rd_bi ? builtin_start(r_ridx[BI_W-1:0])
                               : r_rd_data[ENT_W-1:OFF_W];
    assign cur_off   = r_rd_bi ? builtin_offset(r_ridx[BI_W-1:0])
                               : r_rd_data[OFF_W-1:0];
    assign hit       = (r_t >= cur_start);
    assign rd_en     = (r_state == S_SCAN) && r_iss;
    assign wr_addr   = r_count[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_t         = r_t;
        n_late      = r_late;
        n_idx       = r_idx;
        n_iss       = r_iss;
        n_rvld      = r_rvld;
        n_ridx      = r_ridx;
        n_have_prev = r_have_prev;
        n_prev_m1   = r_prev_m1;
        n_res_st    = r_res_st;
        n_res_off   = r_res_off;
        n_ovr       = r_ovr;
        wr_en       = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_item.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            // drop appends to a full table
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (r_count < CNT_W'(BUILTIN_COUNT)) begin
                                    n_ovr[r_count[BI_W-1:0]] = 1'b1;
                                end
                            end
                        end
                        OP_QUERY: begin
                            n_t         = i_item.arg;
                            n_late      = (i_item.arg > i_expiration);
                            n_have_prev = 1'b0;
                            n_rvld      = 1'b0;
                            if (r_count == '0) begin
                                n_res_st  = STAT_UNKNOWN;
                                n_res_off = '0;
                                n_state   = S_POST;
                            end else begin
                                n_idx   = cnt_m1[IDX_W-1:0];
                                n_iss   = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, newest entry first
                n_rvld = r_iss;
                if (r_iss) begin
                    n_ridx = r_idx;
                    if (r_idx == '0) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
                if (r_rvld) begin
                    if (hit) begin
                        n_res_off = cur_off;
                        if (r_have_prev && (r_t == r_prev_m1)) begin
                            n_res_st = STAT_AMBIG;
                        end else if (r_late) begin
                            n_res_st = STAT_EXPIRED;
                        end else begin
                            n_res_st = STAT_OK;
                        end
                        n_iss   = 1'b0;
                        n_rvld  = 1'b0;
                        n_state = S_POST;
                    end else begin
                        n_prev_m1   = cur_start - TIME_W'(1);
                        n_have_prev = 1'b1;
                        if (r_ridx == '0) begin
                            n_res_st  = STAT_UNKNOWN;
                            n_res_off = '0;
                            n_iss     = 1'b0;
                            n_rvld    = 1'b0;
                            n_state   = S_POST;
                        end
                    end
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(BUILTIN_COUNT);
            r_ovr       <= '0;
            r_iss       <= 1'b0;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovr   <= n_ovr;
            r_iss   <= n_iss;
            r_rvld  <= n_rvld;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_late      <= n_late;
        r_idx       <= n_idx;
        r_ridx      <= n_ridx;
        r_have_prev <= n_have_prev;
        r_prev_m1   <= n_prev_m1;
        r_res_st    <= n_res_st;
        r_res_off   <= n_res_off;
        if (load_out) begin
            r_out_st  <= r_res_st;
            r_out_off <= r_res_off;
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {i_item.arg, i_item.off};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_idx];
            // built-in entries read from the constant table until overwritten
            r_rd_bi   <= (r_idx < IDX_W'(BUILTIN_COUNT)) && !r_ovr[r_idx[BI_W-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_st;
    assign o_leap_offset = r_out_off;
    assign o_stat        = '{busy: (r_state != S_IDLE), count: r_count};

endmodule

### design/leap_second_offset_lookup.sv
// Clear and append take effect once the accepted beat has passed the front register
// and the queue and has been popped by the back end. A query result is registered at the
// output after a scan of the entries (newest first, at most the entry count, up to 256);
// an empty table skips the scan. Queries use the single read port of the entry table one
// at a time; clear and append retire one per cycle while the back end is idle.
// Reset: table holds the 28 built-in epochs at once (no clearing pass), expiry reset.
module leap_second_offset_lookup import lsol_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_cmd,
    input  logic [TIME_W-1:0]        i_entry_ntp,
    input  logic signed [OFF_W-1:0]  i_entry_offset,
    input  logic [TIME_W-1:0]        i_query_time,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [OFF_W-1:0]  o_leap_offset,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TIME_W-1:0]        i_cfg_data
);

    logic [TIME_W-1:0] r_expiration;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    t_item             front_item;
    t_item             queue_item;
    t_bk_status        bk_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiration <= EXPIRY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_expiration <= i_cfg_data;
        end
    end

    lsol_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_entry_ntp    (i_entry_ntp),
        .i_entry_offset (i_entry_offset),
        .i_query_time   (i_query_time),
        .o_push         (push),
        .o_item         (front_item),
        .i_full         (full)
    );

    lsol_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    lsol_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .i_expiration  (r_expiration),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_leap_offset (o_leap_offset),
        .o_stat        (bk_stat)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(bk_stat.busy))
        else $error("result without a query in progress");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_UNKNOWN)) |-> (o_leap_offset == '0))
        else $error("unknown status with nonzero offset");

endmodule
